### rtl/sha_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions.
// ---------------------------------------------------------------------------
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_byte;
      logic start_block;
      logic round_step;
      logic fold;
      logic pad_first;
      logic pad_len;
      logic reinit;
   } cmd_type;

   typedef struct packed {
      logic       block_full;
      logic       pad_extra;
      logic       last_round;
   } status_type;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] PAD_KEEP = 32'hffffff80;
   localparam logic [31:0] PAD_MARK = 32'h00000080;
   localparam logic [5:0]  PAD_LIMIT = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

### rtl/sha_ctrl.sv
// ---------------------------------------------------------------------------
// SHA-256 hasher controller
// Sequences byte loading, compression rounds, padding and digest output.
// ---------------------------------------------------------------------------
module sha_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               in_present,
   input  logic               in_end,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [2:0]         out_index,
   output sha_pkg::cmd_type   cmd,
   input  sha_pkg::status_type stat
);
   import sha_pkg::*;

   state_type  state_ff, state_in;
   logic       end_ff, end_in;
   logic [1:0] pads_ff, pads_in;
   logic [2:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
         pads_ff  <= 2'd0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         pads_ff  <= pads_in;
         idx_ff   <= idx_in;
      end
   end

   // pads_ff is 1 while a length block still follows, 2 while it is under way.
   always_comb begin
      state_in  = state_ff;
      end_in    = end_ff;
      pads_in   = pads_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      out_index = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_byte = in_present;
               end_in = in_end;
               if (in_present && stat.block_full) begin
                  cmd.start_block = 1'b1;
                  state_in = ST_ROUND;
               end else if (in_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (stat.last_round) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (pads_ff != 2'd0) begin
               pads_in = pads_ff - 2'd1;
               state_in = ST_PAD;
            end else if (end_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // end_ff low here means a pending final length block.
            state_in = ST_ROUND;
            cmd.start_block = 1'b1;
            if (end_ff) begin
               cmd.pad_first = 1'b1;
               end_in = 1'b0;
               if (stat.pad_extra) begin
                  pads_in = 2'd1;
               end else begin
                  cmd.pad_len = 1'b1;
                  pads_in = 2'd2;
               end
            end else begin
               cmd.pad_len = 1'b1;
               pads_in = 2'd2;
            end
         end
         ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reinit = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Two in pads_ff marks that the length block is under way: emit next.
      if (state_ff == ST_FOLD && pads_ff == 2'd2) begin
         pads_in = 2'd0;
         state_in = ST_EMIT;
      end
   end

endmodule

### rtl/sha_dp.sv
// ---------------------------------------------------------------------------
// SHA-256 hasher datapath
// Block buffer with in-place schedule, working variables and chain value.
// ---------------------------------------------------------------------------
module sha_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          in_byte,
   input  logic [2:0]          out_index,
   output logic [31:0]         out_word,
   input  sha_pkg::cmd_type    cmd,
   output sha_pkg::status_type stat
);
   import sha_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [60:0] count_ff;
   logic [5:0]  round_ff;
   logic [5:0]  pos;
   logic [3:0]  wi;
   logic [4:0]  sh;
   logic [31:0] s0, s1, wn, wr, t1, t2, mark;
   logic [63:0] bits;

   assign pos  = count_ff[5:0];
   assign wi   = pos[5:2];
   assign sh   = 5'd24 - {pos[1:0], 3'b000};
   assign bits = {count_ff, 3'b000};
   assign stat.block_full = (pos == 6'd63);
   assign stat.pad_extra  = (pos >= PAD_LIMIT);
   assign stat.last_round = (round_ff == 6'd63);
   assign out_word = h_ff[out_index];

   assign s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign wn = w_ff[0] + s0 + w_ff[9] + s1;
   assign wr = w_ff[0];
   assign t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[round_ff] + wr;
   assign t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign mark = (pos[1:0] == 2'd0) ? (PAD_MARK << sh)
               : ((w_ff[wi] & (PAD_KEEP << sh)) | (PAD_MARK << sh));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         round_ff <= '0;
         for (int k = 0; k < 8; k++) h_ff[k] <= INIT_H[k];
      end else begin
         if (cmd.load_byte) begin
            count_ff <= count_ff + 61'd1;
         end
         if (cmd.start_block) begin
            round_ff <= '0;
         end else if (cmd.round_step) begin
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.fold) begin
            for (int k = 0; k < 8; k++) h_ff[k] <= h_ff[k] + v_ff[k];
         end
         if (cmd.reinit) begin
            count_ff <= '0;
            for (int k = 0; k < 8; k++) h_ff[k] <= INIT_H[k];
         end
      end
   end

   // The block buffer rotates one word per round; word 0 always feeds the round.
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         if (pos[1:0] == 2'd0) begin
            w_ff[wi] <= {24'd0, in_byte} << sh;
         end else begin
            w_ff[wi] <= w_ff[wi] | ({24'd0, in_byte} << sh);
         end
      end
      if (cmd.start_block) begin
         for (int k = 0; k < 8; k++) v_ff[k] <= h_ff[k];
         if (cmd.pad_first) begin
            for (int k = 0; k < 16; k++) begin
               if (k[3:0] == wi) begin
                  w_ff[k] <= mark;
               end else if (k[3:0] > wi) begin
                  w_ff[k] <= '0;
               end
            end
            if (cmd.pad_len) begin
               w_ff[14] <= bits[63:32];
               w_ff[15] <= bits[31:0];
            end
         end else if (cmd.pad_len) begin
            for (int k = 0; k < 14; k++) w_ff[k] <= '0;
            w_ff[14] <= bits[63:32];
            w_ff[15] <= bits[31:0];
         end
      end
      if (cmd.round_step) begin
         for (int k = 0; k < 15; k++) w_ff[k] <= w_ff[k + 1];
         w_ff[15] <= wn;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

endmodule

### rtl/sha256_stream_hasher_unit.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words of each message.
// ---------------------------------------------------------------------------
// The req_ channel carries one beat per item: at most one message byte and
// an end-of-message flag. The rsp_ channel returns eight beats per message,
// digest words 0 to 7, the last marked by rsp_tlast.
// A beat that neither fills a block nor ends the message leaves the block
// ready for the next beat. The byte that fills a 64-byte block starts 64
// rounds and a fold, during which req_tready is low. An end beat adds one
// or two padded blocks, then the eight digest beats, one per cycle while
// rsp_tready is high. A stall on the rsp_ side holds the current word; no
// new request is taken until all eight words are delivered. Reset loads
// the initial hash values, clears the byte count and leaves the block idle
// and ready.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word, word_index, 5 zero bits
   output logic        rsp_tlast    // last_word
);
   import sha_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic [2:0]  idx;
   logic [31:0] word;

   sha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_present (req_tuser),
      .in_end     (req_tlast),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_index  (idx),
      .cmd        (cmd),
      .stat       (stat)
   );

   sha_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_tdata),
      .out_index (idx),
      .out_word  (word),
      .cmd       (cmd),
      .stat      (stat)
   );

   assign rsp_tdata = {5'd0, idx, word};
   assign rsp_tlast = (idx == 3'd7);

endmodule
